// File: rtl/fpwalk_pkg.sv
// Shared types, constants and helper functions of the four-level page walker.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package fpwalk_pkg;

  localparam int PA_W     = 52;  // physical address bits in use
  localparam int VA_W     = 48;  // virtual address bits
  localparam int ROOT_W   = 52;  // root table base register width
  localparam int ENTRY_W  = 64;  // page table entry width
  localparam int IDX_W    = 9;   // index bits per level
  localparam int LVL_W    = 3;   // walk level encoding
  localparam int PLVL_W   = 2;   // page size encoding

  // page offset widths
  localparam int OFS_4K = 12;
  localparam int OFS_2M = 21;
  localparam int OFS_1G = 30;

  // entry bit positions
  localparam int BIT_PRESENT = 0;
  localparam int BIT_WRITE   = 1;
  localparam int BIT_USER    = 2;
  localparam int BIT_LARGE   = 7;
  localparam int BIT_NX      = 63;

  // request opcodes
  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_READ_RSP  = 1'b1;

  // result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // walk level state codes
  localparam logic [LVL_W-1:0] LVL_IDLE = 3'd0;
  localparam logic [LVL_W-1:0] LVL_1    = 3'd1;
  localparam logic [LVL_W-1:0] LVL_2    = 3'd2;
  localparam logic [LVL_W-1:0] LVL_3    = 3'd3;
  localparam logic [LVL_W-1:0] LVL_4    = 3'd4;

  // page size codes
  localparam logic [PLVL_W-1:0] PAGE_4K = 2'd0;
  localparam logic [PLVL_W-1:0] PAGE_2M = 2'd1;
  localparam logic [PLVL_W-1:0] PAGE_1G = 2'd2;

  typedef struct packed {
    logic               opcode;
    logic [VA_W-1:0]    lin_addr;
    logic [ENTRY_W-1:0] read_data;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [PA_W-1:0]   read_addr;
    logic              found;
    logic [PA_W-1:0]   xlat_addr;
    logic [PLVL_W-1:0] page_level;
    logic              writable;
    logic              user;
    logic              no_execute;
  } rsp_t;

  // control from the step logic to the state registers
  typedef struct packed {
    logic             emit;
    logic [LVL_W-1:0] lvl_nxt;
    logic             load_vaddr;
  } step_ctl_t;

  // nine index bits of the virtual address for a given level
  function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] vaddr,
                                                   input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      LVL_1:   idx = vaddr[OFS_4K +: IDX_W];
      LVL_2:   idx = vaddr[OFS_4K + IDX_W +: IDX_W];
      LVL_3:   idx = vaddr[OFS_4K + 2*IDX_W +: IDX_W];
      LVL_4:   idx = vaddr[OFS_4K + 3*IDX_W +: IDX_W];
      default: idx = '0;
    endcase
    return idx;
  endfunction

  // page frame from the entry, offset from the virtual address
  function automatic logic [PA_W-1:0] page_addr(input logic [ENTRY_W-1:0] entry,
                                                input logic [VA_W-1:0]    vaddr,
                                                input int                 ofs);
    logic [PA_W-1:0] low_mask;
    low_mask = (PA_W'(1) << ofs) - PA_W'(1);
    return (entry[PA_W-1:0] & ~low_mask) | (PA_W'(vaddr[OFS_1G-1:0]) & low_mask);
  endfunction

endpackage

`default_nettype wire

// File: rtl/fpwalk_ifs.sv
// Valid/ready channel interfaces for walker requests and results.
// Depends on fpwalk_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

interface fpwalk_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [fpwalk_pkg::VA_W-1:0]    lin_addr;
  logic [fpwalk_pkg::ENTRY_W-1:0] read_data;

  modport source (output valid, opcode, lin_addr, read_data, input ready);
  modport sink   (input valid, opcode, lin_addr, read_data, output ready);
endinterface

interface fpwalk_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [fpwalk_pkg::PA_W-1:0]   read_addr;
  logic                         found;
  logic [fpwalk_pkg::PA_W-1:0]   xlat_addr;
  logic [fpwalk_pkg::PLVL_W-1:0] page_level;
  logic                         writable;
  logic                         user;
  logic                         no_execute;

  modport source (output valid, kind, read_addr, found, xlat_addr, page_level,
                  writable, user, no_execute, input ready);
  modport sink   (input valid, kind, read_addr, found, xlat_addr, page_level,
                  writable, user, no_execute, output ready);
endinterface

`default_nettype wire

// File: rtl/fpwalk_step.sv
// One walk step: decodes a request against the walk state, forms the result.
// Depends on fpwalk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpwalk_step (
  input  fpwalk_pkg::req_t                  req,
  input  logic [fpwalk_pkg::LVL_W-1:0]      walk_level,
  input  logic [fpwalk_pkg::VA_W-1:0]       saved_vaddr,
  input  logic [fpwalk_pkg::ROOT_W-1:0]     root_base,
  output fpwalk_pkg::step_ctl_t             ctl,
  output fpwalk_pkg::rsp_t                  rsp
);
  import fpwalk_pkg::*;

  logic [ENTRY_W-1:0] entry;
  logic [LVL_W-1:0]   lvl_dec;
  logic               present;
  logic               ps_bit;

  assign entry   = req.read_data;
  assign lvl_dec = walk_level - LVL_W'(1);
  assign present = entry[BIT_PRESENT];
  assign ps_bit  = entry[BIT_LARGE];

  always_comb begin
    ctl = '{emit: 1'b0, lvl_nxt: walk_level, load_vaddr: 1'b0};
    rsp = '0;
    if (req.opcode == OP_TRANSLATE) begin
      if (walk_level == LVL_IDLE) begin
        ctl.load_vaddr = 1'b1;
        ctl.emit       = 1'b1;
        if (root_base == '0) begin
          rsp.kind = KIND_DONE;    // no table: fail at once
        end else begin
          ctl.lvl_nxt   = LVL_4;
          rsp.kind      = KIND_READ;
          rsp.read_addr = {root_base[PA_W-1:OFS_4K],
                           level_index(req.lin_addr, LVL_4), 3'b000};
        end
      end
    end else if (!(walk_level inside {[LVL_1:LVL_4]})) begin
      ctl.lvl_nxt = LVL_IDLE;      // stray response
    end else begin
      ctl.emit = 1'b1;
      if (!present) begin
        ctl.lvl_nxt = LVL_IDLE;
        rsp.kind    = KIND_DONE;
      end else if ((walk_level == LVL_3 && ps_bit) || (walk_level == LVL_2 && ps_bit) ||
                   walk_level == LVL_1) begin
        ctl.lvl_nxt    = LVL_IDLE;
        rsp.kind       = KIND_DONE;
        rsp.found      = 1'b1;
        rsp.writable   = entry[BIT_WRITE];
        rsp.user       = entry[BIT_USER];
        rsp.no_execute = entry[BIT_NX];
        case (walk_level)
          LVL_3: begin
            rsp.xlat_addr  = page_addr(entry, saved_vaddr, OFS_1G);
            rsp.page_level = PAGE_1G;
          end
          LVL_2: begin
            rsp.xlat_addr  = page_addr(entry, saved_vaddr, OFS_2M);
            rsp.page_level = PAGE_2M;
          end
          default: begin
            rsp.xlat_addr  = page_addr(entry, saved_vaddr, OFS_4K);
            rsp.page_level = PAGE_4K;
          end
        endcase
      end else begin
        ctl.lvl_nxt   = lvl_dec;
        rsp.kind      = KIND_READ;
        rsp.read_addr = {entry[PA_W-1:OFS_4K], level_index(saved_vaddr, lvl_dec), 3'b000};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/four_level_page_walker_unit.sv
// Top level of the four-level page table walker: request stage, walk state,
// result register. Depends on fpwalk_pkg, fpwalk_ifs and fpwalk_step.
//
// Usage:
//   in_ch  (sink)   carries translate requests (opcode 0, lin_addr) and
//                   memory read responses (opcode 1, read_data = entry).
//   out_ch (source) carries memory read requests (kind 0, read_addr) and
//                   walk completions (kind 1, found, xlat_addr, page_level,
//                   writable, user, no_execute).
//   cfg_we/cfg_wdata write the root table base; write it only while idle.
// A walk issues one read request per level visited and expects the matching
// response back on in_ch; a translate request during a walk is dropped,
// as is a response while idle.
// Path: a request taken into the request stage passes through the step logic
// into the result register, which drives out_ch. Throughput: one request per
// cycle unless out_ch stalls; the walk state is updated in the same cycle
// that the request stage hands off, so the next request already sees it.
// Reset (rst_n low, synchronous) empties both stages, returns the walk to
// idle and clears the root base. When out_ch stalls, the result register
// holds and the request stage holds one more request behind it; in_ch.ready
// drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_walker_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  fpwalk_req_if.sink                     in_ch,
  fpwalk_rsp_if.source                   out_ch,
  input  logic                           cfg_we,
  input  logic [fpwalk_pkg::ROOT_W-1:0]  cfg_wdata
);
  import fpwalk_pkg::*;

  // configuration
  logic [ROOT_W-1:0] root_base_r;

  // request stage
  logic s1_valid_r, s1_valid_nxt;
  req_t s1_req_r;
  logic s1_adv;
  logic in_fire;

  // walk state
  logic [LVL_W-1:0] walk_level_r, walk_level_nxt;
  logic [VA_W-1:0]  saved_vaddr_r, saved_vaddr_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  rsp_t out_rsp_r;

  step_ctl_t ctl;
  rsp_t      step_rsp;

  // request stage moves on whenever the result register is free or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_ch.valid && in_ch.ready;

  fpwalk_step u_step (
    .req         (s1_req_r),
    .walk_level  (walk_level_r),
    .saved_vaddr (saved_vaddr_r),
    .root_base   (root_base_r),
    .ctl         (ctl),
    .rsp         (step_rsp)
  );

  always_comb begin
    s1_valid_nxt    = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    walk_level_nxt  = s1_adv ? ctl.lvl_nxt : walk_level_r;
    saved_vaddr_nxt = (s1_adv && ctl.load_vaddr) ? s1_req_r.lin_addr : saved_vaddr_r;
    if (s1_adv) begin
      out_valid_nxt = ctl.emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_base_r   <= '0;
      s1_valid_r    <= 1'b0;
      walk_level_r  <= LVL_IDLE;
      saved_vaddr_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        root_base_r <= cfg_wdata;
      end
      s1_valid_r    <= s1_valid_nxt;
      walk_level_r  <= walk_level_nxt;
      saved_vaddr_r <= saved_vaddr_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.opcode    <= in_ch.opcode;
      s1_req_r.lin_addr  <= in_ch.lin_addr;
      s1_req_r.read_data <= in_ch.read_data;
    end
    if (s1_adv && ctl.emit) begin
      out_rsp_r <= step_rsp;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_rsp_r.kind;
  assign out_ch.read_addr  = out_rsp_r.read_addr;
  assign out_ch.found      = out_rsp_r.found;
  assign out_ch.xlat_addr  = out_rsp_r.xlat_addr;
  assign out_ch.page_level = out_rsp_r.page_level;
  assign out_ch.writable   = out_rsp_r.writable;
  assign out_ch.user       = out_rsp_r.user;
  assign out_ch.no_execute = out_rsp_r.no_execute;

  // walk level never leaves the idle/level-4..1 range
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    walk_level_r <= LVL_4)
    else $error("walk level out of range");

  // issuing a read request leaves a walk in flight
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && ctl.emit && step_rsp.kind == KIND_READ) |=> (walk_level_r != LVL_IDLE))
    else $error("read request issued but walker idle");

  // a completion returns the walker to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && ctl.emit && step_rsp.kind == KIND_DONE) |=> (walk_level_r == LVL_IDLE))
    else $error("walk finished but walker still busy");

  // a translate request during a walk must not disturb the latched address
  a_busy_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_req_r.opcode == OP_TRANSLATE && walk_level_r != LVL_IDLE)
      |=> $stable(saved_vaddr_r))
    else $error("translate request while busy changed saved address");

  // not-found and read results carry no translation
  a_nf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp_r.found) |-> (out_rsp_r.xlat_addr == '0 &&
      out_rsp_r.page_level == PAGE_4K && !out_rsp_r.writable && !out_rsp_r.user &&
      !out_rsp_r.no_execute))
    else $error("unmapped result carries translation fields");

endmodule

`default_nettype wire
